// ----- rtl/mdrfm_pkg.sv -----
// Package for the motor duty ramp and fault monitor.
// Holds widths, duty limits, trip counts, register indexes and shared types.
// No dependencies.
package mdrfm_pkg;

    localparam int DUTY_W = 10;
    localparam int PCT_W  = 8;
    localparam int ADC_W  = 12;
    localparam int TEMP_W = 13;
    localparam int CNT_W  = 8;
    localparam int NUM_CHECKS = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;

    localparam logic [PCT_W-1:0]  PCT_FULL          = 8'd100;
    localparam logic [DUTY_W-1:0] MIN_DUTY_PERMILLE = 10'd100;
    localparam logic [DUTY_W-1:0] MAX_DUTY_PERMILLE = 10'd1000;

    localparam logic [CNT_W-1:0] CURRENT_TRIP_COUNT = 8'd10;
    localparam logic [CNT_W-1:0] BOARD_TRIP_COUNT   = 8'd10;
    localparam logic [CNT_W-1:0] WINDING_TRIP_COUNT = 8'd10;
    localparam logic [CNT_W-1:0] SUPPLY_TRIP_COUNT  = 8'd10;

    // fault bit positions
    localparam int FLT_CURRENT = 0;
    localparam int FLT_BOARD   = 1;
    localparam int FLT_WINDING = 2;
    localparam int FLT_SUPPLY  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP      = 3'd0,
        CFG_CURRENT_LIMIT  = 3'd1,
        CFG_BOARD_HIGH     = 3'd2,
        CFG_BOARD_LOW      = 3'd3,
        CFG_WINDING_HIGH   = 3'd4,
        CFG_WINDING_LOW    = 3'd5,
        CFG_SUPPLY_HIGH    = 3'd6,
        CFG_SUPPLY_LOW     = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_POWER = 1'b1
    } op_t;

    // status of one debounced check, for the item in flight
    typedef struct packed {
        logic flag_now;   // fault bit before this item
        logic flag_next;  // fault bit after this item, if it is a tick
        logic rose;       // fault bit rises on this tick
        logic tripped;    // counter at trip count: forces a stop
    } trip_status_t;

endpackage

// ----- rtl/mdrfm_trip_check.sv -----
// One debounced fault check: saturating trip counter plus a fault bit that clears on an in-range sample.
// Depends on mdrfm_pkg.
module mdrfm_trip_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,      // tick beat is consumed
    input  logic                        bad,     // sample out of range
    input  logic [mdrfm_pkg::CNT_W-1:0] trip,
    output mdrfm_pkg::trip_status_t     status
);
    import mdrfm_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_next;
    logic             flag_reg;
    logic             tripped;

    always_comb
    begin
        count_inc = count_reg;
        if (count_reg < trip && count_reg != {CNT_W{1'b1}})
        begin
            count_inc = count_reg + 1'b1;
        end
        tripped    = bad && (count_inc >= trip);
        count_next = bad ? count_inc : '0;

        status.flag_now  = flag_reg;
        status.flag_next = bad ? (flag_reg | tripped) : 1'b0;
        status.rose      = tripped & ~flag_reg;
        status.tripped   = tripped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (en)
        begin
            count_reg <= count_next;
            flag_reg  <= status.flag_next;
        end
    end

endmodule

// ----- rtl/motor_duty_ramp_fault_monitor_unit.sv -----
// Top level of the motor duty ramp and fault monitor.
// Depends on mdrfm_pkg and mdrfm_trip_check.
//
// Each input beat is either a set-power command (tuser = 1) or a control tick
// carrying four samples (tuser = 0), and yields exactly one result beat with
// the applied duty, run state, fault bits and a report pulse. A beat is first
// captured in an input register; when it moves on, the ramp, the four window
// checks and their trip counters are evaluated in one shallow combinational
// pass and the result lands in the output register. One beat per cycle is
// sustained while the output does not stall: the only loop is the state update
// (duty, run flag, counters). The input side keeps accepting while a result
// waits, as long as the output register will free up in that cycle; a stalled
// output backs up through the input register only. Commands start the motor
// even with faults set; a fault that trips on a tick stops the motor and
// reports 0 duty in that very result. Current and supply are compared as raw
// ADC codes, temperatures as signed tenths of a degree. Configuration is
// written through cfg_we / cfg_index / cfg_data and should only change while
// no beat is in flight.
module motor_duty_ramp_fault_monitor_unit (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [mdrfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdrfm_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // power_percent[7:0], current_code[19:8], board_temp[32:20],
    // winding_temp[45:33], supply_code[57:46], zero pad[63:58]
    input  logic [mdrfm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                             s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // applied_duty[9:0], running[10], fault_bits[14:11], report_now[15]
    output logic [mdrfm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mdrfm_pkg::*;

    // ---------------- configuration registers
    logic        [DUTY_W-1:0] ramp_step_reg;
    logic        [ADC_W-1:0]  current_limit_reg;
    logic signed [TEMP_W-1:0] board_high_reg;
    logic signed [TEMP_W-1:0] board_low_reg;
    logic signed [TEMP_W-1:0] winding_high_reg;
    logic signed [TEMP_W-1:0] winding_low_reg;
    logic        [ADC_W-1:0]  supply_high_reg;
    logic        [ADC_W-1:0]  supply_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg     <= 10'd50;
            current_limit_reg <= 12'd4095;
            board_high_reg    <= 13'sd800;
            board_low_reg     <= -13'sd200;
            winding_high_reg  <= 13'sd1000;
            winding_low_reg   <= -13'sd200;
            supply_high_reg   <= 12'd4095;
            supply_low_reg    <= 12'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RAMP_STEP:     ramp_step_reg     <= cfg_data[DUTY_W-1:0];
                CFG_CURRENT_LIMIT: current_limit_reg <= cfg_data[ADC_W-1:0];
                CFG_BOARD_HIGH:    board_high_reg    <= cfg_data;
                CFG_BOARD_LOW:     board_low_reg     <= cfg_data;
                CFG_WINDING_HIGH:  winding_high_reg  <= cfg_data;
                CFG_WINDING_LOW:   winding_low_reg   <= cfg_data;
                CFG_SUPPLY_HIGH:   supply_high_reg   <= cfg_data[ADC_W-1:0];
                CFG_SUPPLY_LOW:    supply_low_reg    <= cfg_data[ADC_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- input register
    logic                     in_valid_reg;
    logic                     in_valid_next;
    op_t                      in_op_reg;
    logic        [PCT_W-1:0]  in_pct_reg;
    logic        [ADC_W-1:0]  in_current_reg;
    logic signed [TEMP_W-1:0] in_board_reg;
    logic signed [TEMP_W-1:0] in_winding_reg;
    logic        [ADC_W-1:0]  in_supply_reg;

    logic out_valid_reg;
    logic out_valid_next;
    logic advance;     // input register hands its beat to the result stage
    logic in_accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg      <= op_t'(s_axis_tuser);
            in_pct_reg     <= s_axis_tdata[7:0];
            in_current_reg <= s_axis_tdata[19:8];
            in_board_reg   <= s_axis_tdata[32:20];
            in_winding_reg <= s_axis_tdata[45:33];
            in_supply_reg  <= s_axis_tdata[57:46];
        end
    end

    // ---------------- motor state
    logic [DUTY_W-1:0] target_duty_reg;
    logic [DUTY_W-1:0] target_duty_next;
    logic [DUTY_W-1:0] duty_now_reg;
    logic [DUTY_W-1:0] duty_now_next;
    logic              run_reg;
    logic              run_next;

    logic              is_tick;
    logic [6:0]        pct_clamp;
    logic [DUTY_W:0]   pct_x10;
    logic [DUTY_W-1:0] cmd_duty;
    logic [DUTY_W:0]   up_sum;
    logic [DUTY_W:0]   dn_sum;
    logic [DUTY_W-1:0] ramped;

    assign is_tick = (in_op_reg == OP_TICK);

    // ---------------- fault checks
    logic                      bad [NUM_CHECKS];
    logic [CNT_W-1:0]          trip_cnt [NUM_CHECKS];
    trip_status_t              chk [NUM_CHECKS];
    logic [NUM_CHECKS-1:0]     flags_now;
    logic [NUM_CHECKS-1:0]     flags_next;
    logic [NUM_CHECKS-1:0]     rose_vec;
    logic [NUM_CHECKS-1:0]     trip_vec;

    always_comb
    begin
        bad[FLT_CURRENT] = in_current_reg > current_limit_reg;
        bad[FLT_BOARD]   = (in_board_reg > board_high_reg)
                         || (in_board_reg < board_low_reg);
        bad[FLT_WINDING] = (in_winding_reg > winding_high_reg)
                         || (in_winding_reg < winding_low_reg);
        bad[FLT_SUPPLY]  = (in_supply_reg > supply_high_reg)
                         || (in_supply_reg < supply_low_reg);
        trip_cnt[FLT_CURRENT] = CURRENT_TRIP_COUNT;
        trip_cnt[FLT_BOARD]   = BOARD_TRIP_COUNT;
        trip_cnt[FLT_WINDING] = WINDING_TRIP_COUNT;
        trip_cnt[FLT_SUPPLY]  = SUPPLY_TRIP_COUNT;
    end

    for (genvar g = 0; g < NUM_CHECKS; g++)
    begin : g_check
        mdrfm_trip_check u_check (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (advance && is_tick),
            .bad    (bad[g]),
            .trip   (trip_cnt[g]),
            .status (chk[g])
        );
        assign flags_now[g]  = chk[g].flag_now;
        assign flags_next[g] = chk[g].flag_next;
        assign rose_vec[g]   = chk[g].rose;
        assign trip_vec[g]   = chk[g].tripped;
    end

    // ---------------- command duty and ramp
    always_comb
    begin
        pct_clamp = (in_pct_reg > PCT_FULL) ? PCT_FULL[6:0] : in_pct_reg[6:0];
        pct_x10   = {1'b0, pct_clamp, 3'b000} + {3'b000, pct_clamp, 1'b0};
        if (pct_x10 < {1'b0, MIN_DUTY_PERMILLE})
        begin
            cmd_duty = MIN_DUTY_PERMILLE;
        end
        else if (pct_x10 >= {1'b0, MAX_DUTY_PERMILLE})
        begin
            cmd_duty = MAX_DUTY_PERMILLE;
        end
        else
        begin
            cmd_duty = pct_x10[DUTY_W-1:0];
        end

        up_sum = {1'b0, duty_now_reg} + {1'b0, ramp_step_reg};
        dn_sum = {1'b0, target_duty_reg} + {1'b0, ramp_step_reg};
        ramped = duty_now_reg;
        if (target_duty_reg > duty_now_reg)
        begin
            ramped = ({1'b0, target_duty_reg} > up_sum) ? up_sum[DUTY_W-1:0]
                                                       : target_duty_reg;
        end
        else if (target_duty_reg < duty_now_reg)
        begin
            ramped = (dn_sum < {1'b0, duty_now_reg}) ? duty_now_reg - ramp_step_reg
                                                    : target_duty_reg;
        end
    end

    // ---------------- next state and result
    logic [NUM_CHECKS-1:0] res_flags;
    logic                  res_report;

    always_comb
    begin
        target_duty_next = target_duty_reg;
        duty_now_next    = duty_now_reg;
        run_next         = run_reg;
        res_flags        = flags_now;
        res_report       = 1'b0;
        if (in_op_reg == OP_POWER)
        begin
            if (in_pct_reg == '0)
            begin
                run_next      = 1'b0;
                duty_now_next = '0;
            end
            else
            begin
                target_duty_next = cmd_duty;
                run_next         = 1'b1;
            end
        end
        else
        begin
            if (run_reg)
            begin
                duty_now_next = ramped;
            end
            if (|trip_vec)
            begin
                run_next      = 1'b0;
                duty_now_next = '0;
            end
            res_flags  = flags_next;
            res_report = |rose_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_duty_reg <= '0;
            duty_now_reg    <= '0;
            run_reg         <= 1'b0;
        end
        else if (advance)
        begin
            target_duty_reg <= target_duty_next;
            duty_now_reg    <= duty_now_next;
            run_reg         <= run_next;
        end
    end

    // ---------------- output register
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {res_report, res_flags, run_next, duty_now_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- tb/sv/mdrfm_duty_fault_checker.sv -----
`timescale 1ns / 1ps
// Checker for motor_duty_ramp_fault_monitor_unit. It follows the config port,
// predicts one status beat per accepted input beat and compares the output stream.
// Depends on mdrfm_pkg.
module mdrfm_duty_fault_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mdrfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdrfm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [mdrfm_pkg::IN_DATA_W-1:0]  s_data,
    input  logic                             s_user,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [mdrfm_pkg::OUT_DATA_W-1:0] m_data,
    output int                               fail_count,
    output int                               pending
);
    import mdrfm_pkg::*;

    // same layout as the output tdata, duty in the low bits
    typedef struct packed {
        logic                  report;
        logic [NUM_CHECKS-1:0] faults;
        logic                  running;
        logic [DUTY_W-1:0]     duty;
    } drive_status_t;

    logic [DUTY_W-1:0]        ramp_step_r;
    logic [ADC_W-1:0]         current_limit_r;
    logic [ADC_W-1:0]         supply_high_r;
    logic [ADC_W-1:0]         supply_low_r;
    logic signed [TEMP_W-1:0] board_high_r;
    logic signed [TEMP_W-1:0] board_low_r;
    logic signed [TEMP_W-1:0] winding_high_r;
    logic signed [TEMP_W-1:0] winding_low_r;

    logic [DUTY_W-1:0]     target_r;
    logic [DUTY_W-1:0]     duty_r;
    logic                  run_r;
    logic [NUM_CHECKS-1:0] fault_r;
    logic [CNT_W-1:0]      trip_cnt [NUM_CHECKS];

    drive_status_t expected_status_q [$];
    int mismatch_count = 0;
    int pending_r = 0;

    assign fail_count = mismatch_count;
    assign pending    = pending_r;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void stop_drive();
        run_r  = 1'b0;
        duty_r = '0;
    endfunction

    // debounced window check; returns 1 when the fault bit rises
    function automatic logic debounce(input logic bad, input int chk,
                                      input logic [CNT_W-1:0] trip);
        logic rose;
        rose = 1'b0;
        if (bad)
        begin
            if (trip_cnt[chk] < trip && trip_cnt[chk] < 8'd255)
                trip_cnt[chk] = trip_cnt[chk] + 1'b1;
            if (trip_cnt[chk] >= trip)
            begin
                rose = !fault_r[chk];
                fault_r[chk] = 1'b1;
                stop_drive();
            end
        end
        else
        begin
            fault_r[chk]  = 1'b0;
            trip_cnt[chk] = '0;
        end
        return rose;
    endfunction

    function automatic drive_status_t advance_drive(input op_t op,
                                                    input logic [IN_DATA_W-1:0] data);
        logic [PCT_W-1:0]         pct;
        logic [ADC_W-1:0]         cur;
        logic [ADC_W-1:0]         sup;
        logic signed [TEMP_W-1:0] bt;
        logic signed [TEMP_W-1:0] wt;
        int                       t;
        int                       d;
        int                       st;
        logic                     rose_any;
        drive_status_t            res;
        pct = data[7:0];
        cur = data[19:8];
        bt  = data[32:20];
        wt  = data[45:33];
        sup = data[57:46];
        rose_any = 1'b0;
        if (op == OP_POWER)
        begin
            if (pct > PCT_FULL)
                pct = PCT_FULL;
            if (pct != '0)
            begin
                d = int'(pct) * 10;
                if (d < int'(MIN_DUTY_PERMILLE))
                    d = int'(MIN_DUTY_PERMILLE);
                else if (d >= int'(MAX_DUTY_PERMILLE))
                    d = int'(MAX_DUTY_PERMILLE);
                target_r = d[DUTY_W-1:0];
                run_r    = 1'b1;
            end
            else
                stop_drive();
        end
        else
        begin
            // ramp first, then the checks
            if (run_r)
            begin
                t  = int'(target_r);
                d  = int'(duty_r);
                st = int'(ramp_step_r);
                if (t > d)
                    d = (t > d + st) ? d + st : t;
                else if (t < d)
                    d = (t + st < d) ? d - st : t;
                duty_r = d[DUTY_W-1:0];
            end
            rose_any |= debounce(cur > current_limit_r, FLT_CURRENT, CURRENT_TRIP_COUNT);
            rose_any |= debounce(bt > board_high_r || bt < board_low_r,
                                 FLT_BOARD, BOARD_TRIP_COUNT);
            rose_any |= debounce(wt > winding_high_r || wt < winding_low_r,
                                 FLT_WINDING, WINDING_TRIP_COUNT);
            rose_any |= debounce(sup > supply_high_r || sup < supply_low_r,
                                 FLT_SUPPLY, SUPPLY_TRIP_COUNT);
        end
        res.duty    = duty_r;
        res.running = run_r;
        res.faults  = fault_r;
        res.report  = rose_any;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_status_t got;
        drive_status_t want;
        if (!rst_n)
        begin
            ramp_step_r     = 10'd50;
            current_limit_r = 12'd4095;
            board_high_r    = 13'sd800;
            board_low_r     = -13'sd200;
            winding_high_r  = 13'sd1000;
            winding_low_r   = -13'sd200;
            supply_high_r   = 12'd4095;
            supply_low_r    = 12'd0;
            target_r = '0;
            duty_r   = '0;
            run_r    = 1'b0;
            fault_r  = '0;
            for (int c = 0; c < NUM_CHECKS; c++)
                trip_cnt[c] = '0;
            expected_status_q.delete();
            pending_r <= 0;
        end
        else
        begin
            // output first: a result never belongs to a beat taken at the same edge
            if (m_valid && m_ready)
            begin
                got = m_data;
                if (expected_status_q.size() == 0)
                    report_mismatch("result beat with nothing pending", int'(got), 0);
                else
                begin
                    want = expected_status_q.pop_front();
                    if (got.duty !== want.duty)
                        report_mismatch("applied_duty", got.duty, want.duty);
                    if (got.running !== want.running)
                        report_mismatch("running", got.running, want.running);
                    if (got.faults !== want.faults)
                        report_mismatch("fault_bits", got.faults, want.faults);
                    if (got.report !== want.report)
                        report_mismatch("report_now", got.report, want.report);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_RAMP_STEP:     ramp_step_r     = cfg_data[DUTY_W-1:0];
                    CFG_CURRENT_LIMIT: current_limit_r = cfg_data[ADC_W-1:0];
                    CFG_BOARD_HIGH:    board_high_r    = cfg_data;
                    CFG_BOARD_LOW:     board_low_r     = cfg_data;
                    CFG_WINDING_HIGH:  winding_high_r  = cfg_data;
                    CFG_WINDING_LOW:   winding_low_r   = cfg_data;
                    CFG_SUPPLY_HIGH:   supply_high_r   = cfg_data[ADC_W-1:0];
                    CFG_SUPPLY_LOW:    supply_low_r    = cfg_data[ADC_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_status_q.push_back(advance_drive(op_t'(s_user), s_data));
            pending_r <= expected_status_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_motor_duty_ramp_fault_monitor_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for motor_duty_ramp_fault_monitor_unit: clock, reset, config
// phases, input beats, output back-pressure, watchdog and verdict.
// Depends on mdrfm_pkg, the block RTL and mdrfm_duty_fault_checker.
module tb_motor_duty_ramp_fault_monitor_unit;
    import mdrfm_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int HOLD_OFF_CYCLES = 200;   // long output stall in the pressure phase
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES   = 4;     // settle margin after the last pending result
    localparam int TEMP_FLOOR      = -550;
    localparam int TEMP_CEIL       = 3000;
    localparam int CODE_CEIL       = 4095;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;

    // idle percentages, set per phase by the stimulus
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // hold-off handshake between stimulus and receiver: one writer per counter
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int quiet_cycles = 0;

    // limits as last written; only used to aim samples in or out of range
    int cfg_shadow [8] = '{50, 4095, 800, -200, 1000, -200, 4095, 0};
    // remaining length of an out-of-range run, per check
    int bad_left [NUM_CHECKS] = '{0, 0, 0, 0};

    always #5 clk = ~clk;

    motor_duty_ramp_fault_monitor_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mdrfm_duty_fault_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_user     (s_axis_tuser),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls, or a fixed hold-off when the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: any accepted beat on either side restarts the count.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_beat(input int pct, input int cur,
                                                       input int bt, input int wt,
                                                       input int sup);
        logic [IN_DATA_W-1:0] beat;
        beat         = '0;
        beat[7:0]    = pct[7:0];
        beat[19:8]   = cur[11:0];
        beat[32:20]  = bt[12:0];
        beat[45:33]  = wt[12:0];
        beat[57:46]  = sup[11:0];
        return beat;
    endfunction

    function automatic int rand_temp();
        return TEMP_FLOOR + int'($urandom_range(TEMP_CEIL - TEMP_FLOOR));
    endfunction

    // Sample inside [lo, hi] when good, outside it when bad. Crossed limits have
    // no inside, so a good pick is then just any legal value.
    function automatic int pick_sample(input bit bad, input int lo, input int hi,
                                       input int floor_v, input int ceil_v);
        bit above_ok;
        bit below_ok;
        above_ok = hi < ceil_v;
        below_ok = lo > floor_v;
        if (!bad && lo <= hi)
            return lo + int'($urandom_range(hi - lo));
        if (bad && above_ok && (!below_ok || $urandom_range(1) == 1))
            return hi + 1 + int'($urandom_range(ceil_v - hi - 1));
        if (bad && below_ok)
            return floor_v + int'($urandom_range(lo - 1 - floor_v));
        return floor_v + int'($urandom_range(ceil_v - floor_v));
    endfunction

    // Offer one beat, with random idle cycles ahead of it; returns at the
    // edge where it is accepted.
    task automatic send_beat(input op_t op, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_tick(input int cur, input int bt, input int wt, input int sup);
        // percent field is don't-care on a tick
        send_beat(OP_TICK, pack_beat($urandom_range(255), cur, bt, wt, sup));
    endtask

    task automatic send_power(input int pct);
        // sample fields are ignored on a command, so fill them with noise
        send_beat(OP_POWER, pack_beat(pct, $urandom_range(CODE_CEIL), rand_temp(),
                                      rand_temp(), $urandom_range(CODE_CEIL)));
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        cfg_we          <= 1'b1;
        cfg_index       <= idx;
        cfg_data        <= val[CFG_DATA_W-1:0];
        cfg_shadow[idx]  = val;
        @(posedge clk);
    endtask

    // Stop offering beats and wait for every pending result, plus the latency.
    // pending is registered, hence the first wait.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int n_items;
        int pct;
        bit bad [NUM_CHECKS];
        int lo;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Config changes only with the pipe empty. Phase 0 runs on reset values.
            if (phase > 0)
            begin
                drain_results();
                case (phase)
                    1:
                    begin
                        // widest windows, fastest ramp, current always over unless zero
                        write_reg(CFG_RAMP_STEP, 1000);
                        write_reg(CFG_CURRENT_LIMIT, 0);
                        write_reg(CFG_BOARD_HIGH, TEMP_CEIL);
                        write_reg(CFG_BOARD_LOW, TEMP_FLOOR);
                        write_reg(CFG_WINDING_HIGH, TEMP_CEIL);
                        write_reg(CFG_WINDING_LOW, TEMP_FLOOR);
                        write_reg(CFG_SUPPLY_HIGH, CODE_CEIL);
                        write_reg(CFG_SUPPLY_LOW, 0);
                    end
                    2:
                    begin
                        // slowest ramp, mid-range windows
                        write_reg(CFG_RAMP_STEP, 1);
                        write_reg(CFG_CURRENT_LIMIT, 2000);
                        write_reg(CFG_BOARD_HIGH, 500);
                        write_reg(CFG_BOARD_LOW, 0);
                        write_reg(CFG_WINDING_HIGH, 700);
                        write_reg(CFG_WINDING_LOW, 100);
                        write_reg(CFG_SUPPLY_HIGH, 3000);
                        write_reg(CFG_SUPPLY_LOW, 1000);
                    end
                    3:
                    begin
                        // zero ramp step; board and supply windows crossed,
                        // so those samples are out of range from either side
                        write_reg(CFG_RAMP_STEP, 0);
                        write_reg(CFG_CURRENT_LIMIT, CODE_CEIL);
                        write_reg(CFG_BOARD_HIGH, TEMP_FLOOR);
                        write_reg(CFG_BOARD_LOW, TEMP_CEIL);
                        write_reg(CFG_WINDING_HIGH, 1500);
                        write_reg(CFG_WINDING_LOW, -100);
                        write_reg(CFG_SUPPLY_HIGH, 1000);
                        write_reg(CFG_SUPPLY_LOW, 3000);
                    end
                    default:
                    begin
                        write_reg(CFG_RAMP_STEP, $urandom_range(1000, 1));
                        write_reg(CFG_CURRENT_LIMIT, $urandom_range(CODE_CEIL));
                        lo = rand_temp();
                        write_reg(CFG_BOARD_LOW, lo);
                        write_reg(CFG_BOARD_HIGH, lo + int'($urandom_range(TEMP_CEIL - lo)));
                        lo = rand_temp();
                        write_reg(CFG_WINDING_LOW, lo);
                        write_reg(CFG_WINDING_HIGH, lo + int'($urandom_range(TEMP_CEIL - lo)));
                        lo = $urandom_range(CODE_CEIL);
                        write_reg(CFG_SUPPLY_LOW, lo);
                        write_reg(CFG_SUPPLY_HIGH, lo + int'($urandom_range(CODE_CEIL - lo)));
                    end
                endcase
                cfg_we <= 1'b0;
            end

            // idle pattern: none / sender idle / receiver stall / both lightly
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase

            // back-pressure: output held off while the sender keeps offering
            if (phase == 4)
                hold_requests++;

            if (phase == 0)
            begin
                send_tick(1000, 250, 300, 2000);    // stopped tick: checks run, no ramp
                send_power(0);                      // stop while already stopped
                send_power(1);                      // 10 permille, raised to min duty
                send_tick(1000, 250, 300, 2000);
                send_power(255);                    // clamps to full power
                send_tick(4095, 800, 1000, 4095);   // every sample on its upper limit
                send_tick(0, -200, -200, 0);        // and on its lower limit
                send_power(101);
                send_power(55);
                send_tick(1000, 250, 300, 2000);
                send_power(10);                     // target at min duty, ramp down
                send_tick(1000, 250, 300, 2000);
                send_tick(1000, 250, 300, 2000);
                send_tick(0, -550, 3000, 2000);     // one bad tick, below trip count
                send_tick(1000, 250, 300, 2000);    // clears those counters
                // board hot and motor cold together: both trip on the tenth tick
                repeat (10) send_tick(2000, 3000, -550, 2000);
                send_power(50);                     // restart with faults still set
                send_tick(1000, 250, 300, 2000);    // samples back in range clear them
            end

            n_items = (phase == 0) ? 40 : 70;
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    case ($urandom_range(9))
                        0, 1:    pct = 0;
                        2, 3, 4: pct = $urandom_range(255);
                        default: pct = $urandom_range(100, 1);
                    endcase
                    send_power(pct);
                end
                else if ($urandom_range(99) < 10)
                    send_tick($urandom_range(CODE_CEIL), rand_temp(), rand_temp(),
                              $urandom_range(CODE_CEIL));
                else
                begin
                    // out-of-range runs of random length; the long ones trip
                    for (int c = 0; c < NUM_CHECKS; c++)
                    begin
                        if (bad_left[c] == 0 && $urandom_range(99) < 6)
                            bad_left[c] = $urandom_range(14, 1);
                        bad[c] = bad_left[c] > 0;
                        if (bad_left[c] > 0)
                            bad_left[c]--;
                    end
                    send_tick(pick_sample(bad[FLT_CURRENT], 0, cfg_shadow[CFG_CURRENT_LIMIT],
                                          0, CODE_CEIL),
                              pick_sample(bad[FLT_BOARD], cfg_shadow[CFG_BOARD_LOW],
                                          cfg_shadow[CFG_BOARD_HIGH], TEMP_FLOOR, TEMP_CEIL),
                              pick_sample(bad[FLT_WINDING], cfg_shadow[CFG_WINDING_LOW],
                                          cfg_shadow[CFG_WINDING_HIGH], TEMP_FLOOR, TEMP_CEIL),
                              pick_sample(bad[FLT_SUPPLY], cfg_shadow[CFG_SUPPLY_LOW],
                                          cfg_shadow[CFG_SUPPLY_HIGH], 0, CODE_CEIL));
                end
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
